FILE: design/i2cmts_pkg.sv
package i2cmts_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 255;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START_SENT  = 8'h08;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef enum logic [1:0] {
    OUTC_BUSY  = 2'd0,
    OUTC_DONE  = 2'd1,
    OUTC_ERROR = 2'd2
  } outcome_t;

  // Packed so that the last field sits in the lowest bits of tdata.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] status_code;
    logic [7:0] byte_count;
    logic       read_request;
    logic [6:0] device_address;
  } in_item_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [7:0] remaining;
    logic [7:0] rx_data;
    logic       rx_store;
    logic [7:0] buffer_index;
    logic [7:0] tx_data;
    logic       tx_valid;
    logic       send_stop;
    logic       clear_start;
    logic       send_start;
    logic       ack_next;
  } result_t;

  typedef struct packed {
    logic [7:0] bytes_left;
    logic [7:0] byte_position;
    logic [7:0] address_byte;
    logic       failed;
  } seq_state_t;

endpackage

FILE: design/i2c_master_transfer_sequencer.sv
// Sequences one I2C master read or write from the status codes of a byte engine.
// The input stream carries one beat per event. in_tuser is the kind: a start
// beat latches the slave address, direction and byte count and requests START;
// a status beat carries the engine status code, the received byte and the
// write buffer byte at the current position.
// Every input beat produces exactly one result beat with the control actions
// for the engine: address or data byte to load, received byte to store, the
// ACK choice for the next byte, START/STOP requests and the outcome.
// Each beat goes to the input register, then the status decode and the sequencer
// state update write the result register. Throughput is one beat per cycle
// while out_tready holds; the state update for a beat completes in the same
// cycle its result is registered, so beats may follow back to back.
// When the receiver stalls, the result beat holds and the input register
// still takes one more beat; in_tready then drops until the result moves.
// Reset clears both valid flags and the sequencer state (count, position,
// address byte and the failure flag).
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // device_address[6:0], read_request[7], byte_count[15:8], status_code[23:16],
  // rx_byte[31:24], tx_byte[39:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // ack_next[0], send_start[1], clear_start[2], send_stop[3], tx_valid[4],
  // tx_data[12:5], buffer_index[20:13], rx_store[21], rx_data[29:22],
  // remaining[37:30], outcome[39:38]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       in_valid_r;
  logic       in_kind_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res_nxt;
  logic       out_free;
  logic       advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  i2cmts_step #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_step (
    .kind     (in_kind_r),
    .item     (in_item_r),
    .state    (state_r),
    .res      (res_nxt),
    .state_nxt(state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= in_tuser;
      in_item_r <= in_item_t'(in_tdata);
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

FILE: design/i2cmts_step.sv
module i2cmts_step
  import i2cmts_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       kind,
  input  in_item_t   item,
  input  seq_state_t state,
  output result_t    res,
  output seq_state_t state_nxt
);

  localparam logic [15:0] MaxLen = 16'(MAX_LENGTH);

  logic [15:0] cnt_ext;
  logic [7:0]  left_dec;
  logic [7:0]  pos_inc;

  assign cnt_ext  = {8'b0, item.byte_count};
  assign left_dec = state.bytes_left - 8'd1;
  assign pos_inc  = state.byte_position + 8'd1;

  always_comb begin
    res              = '0;
    res.ack_next     = 1'b1;
    res.outcome      = OUTC_BUSY;
    res.buffer_index = state.byte_position;
    state_nxt        = state;

    if (kind == KIND_START) begin
      state_nxt.address_byte  = {item.device_address, item.read_request};
      state_nxt.bytes_left    = (cnt_ext > MaxLen) ? MaxLen[7:0] : item.byte_count;
      state_nxt.byte_position = 8'd0;
      state_nxt.failed        = 1'b0;
      res.ack_next            = 1'b0;
      res.send_start          = 1'b1;
      res.buffer_index        = 8'd0;
    end else begin
      case (item.status_code)
        ST_BUS_ERROR, ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
          res.send_stop        = 1'b1;
          res.outcome          = OUTC_ERROR;
          state_nxt.bytes_left = 8'd0;
          state_nxt.failed     = 1'b1;
        end
        ST_START_SENT: begin
          res.clear_start         = 1'b1;
          res.tx_valid            = 1'b1;
          res.tx_data             = state.address_byte;
          res.buffer_index        = 8'd0;
          state_nxt.byte_position = 8'd0;
        end
        ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
          if (state.bytes_left != 8'd0) begin
            res.tx_valid            = 1'b1;
            res.tx_data             = item.tx_byte;
            state_nxt.byte_position = pos_inc;
            state_nxt.bytes_left    = left_dec;
          end else begin
            res.send_stop = 1'b1;
            res.outcome   = OUTC_DONE;
          end
        end
        ST_ADDR_R_ACK: begin
          state_nxt.byte_position = 8'd0;
          res.buffer_index        = 8'd0;
          res.ack_next            = (state.bytes_left > 8'd1);
        end
        ST_DATA_R_ACK: begin
          if (state.bytes_left != 8'd0) begin
            res.rx_store            = 1'b1;
            res.rx_data             = item.rx_byte;
            state_nxt.byte_position = pos_inc;
            state_nxt.bytes_left    = left_dec;
            res.ack_next            = (left_dec > 8'd1);
          end else begin
            res.ack_next = 1'b0;
          end
        end
        ST_DATA_R_NACK: begin
          if (state.bytes_left != 8'd0) begin
            res.rx_store            = 1'b1;
            res.rx_data             = item.rx_byte;
            state_nxt.byte_position = pos_inc;
          end
          state_nxt.bytes_left = 8'd0;
          res.send_stop        = 1'b1;
          res.outcome          = OUTC_DONE;
        end
        default: begin
          res.outcome = state.failed ? OUTC_ERROR : OUTC_BUSY;
        end
      endcase
    end

    res.remaining = state_nxt.bytes_left;
  end

endmodule

FILE: design/i2cmts_checker.sv
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A result beat held by the receiver must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A beat never both loads a byte for transmit and stores a received byte.
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[21]))
    else $error("transmit load and receive store in one beat");

  // STOP is only requested when the transfer ends, in success or error.
  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[39:38] != 2'd0)
    else $error("STOP requested with a busy outcome");

  // A START request comes with no other bus action and a NACK choice.
  a_start_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |->
      !out_tdata[0] && !out_tdata[2] && !out_tdata[3] && !out_tdata[4] && !out_tdata[21])
    else $error("START request mixed with other actions");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (.*);
